// ===== rtl/nfcplan_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nfcplan_pkg
// shared types, codes and constants of the tag linear access planner
// ----------------------------------------------------------------------------
package nfcplan_pkg;

   // transfer limits and tag geometry
   localparam int MAX_TRANSFER      = 256;
   localparam int DATA_BLOCKS       = 47;
   localparam int MAX_RESULTS       = 64;
   localparam int FIRST_DATA_PAGE   = 4;
   localparam int CNT_W             = $clog2(MAX_RESULTS);

   localparam logic [9:0] CAPACITY_RESET = 10'd752;

   typedef enum logic [1:0] {
      ACT_READ    = 2'd0,
      ACT_WRITE   = 2'd1,
      ACT_RELEASE = 2'd2,
      ACT_UNDEF   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      CMD_AUTH  = 2'd0,
      CMD_READ  = 2'd1,
      CMD_WRITE = 2'd2,
      CMD_NONE  = 2'd3
   } command_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_BAD_ARG  = 3'd1,
      ST_RANGE    = 3'd2,
      ST_BEYOND   = 3'd3,
      ST_RESERVED = 3'd4
   } status_type;

   typedef enum logic {
      CSR_TAG_KIND = 1'b0,
      CSR_CAPACITY = 1'b1
   } csr_index_type;

   typedef enum logic {
      BK_IDLE = 1'b0,
      BK_RUN  = 1'b1
   } back_state_type;

   // classified request handed from front to back
   typedef struct packed {
      logic       run;
      logic       rel_session;
      status_type status;
      logic       writing;
      logic       paged;
      logic [9:0] offset;
      logic [8:0] length;
   } job_type;

   typedef struct packed {
      command_type command;
      logic [7:0]  unit_address;
      logic [3:0]  skip_bytes;
      logic [4:0]  take_bytes;
      status_type  status;
      logic        last;
   } rsp_type;

   // data-block index to physical block, skipping block 0 and sector trailers
   // rest / 3 done as rest * 43 >> 7, exact for every 6-bit rest
   function automatic logic [7:0] block_of(input logic [5:0] idx);
      logic [5:0]  rest;
      logic [11:0] prod;
      logic [4:0]  quo;
      logic [5:0]  rem3;
      logic [7:0]  addr;
      rest = idx - 6'd2;
      prod = {6'd0, rest} * 12'd43;
      quo  = prod[11:7];
      rem3 = rest - {quo, 1'b0} - {1'b0, quo};
      if (idx < 6'd2) begin
         addr = {2'd0, idx} + 8'd1;
      end else begin
         addr = {1'b0, quo + 5'd1, 2'b00} + {2'd0, rem3};
      end
      return addr;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/nfcplan_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nfcplan_fifo
// small register queue with first-word fall-through read
// ----------------------------------------------------------------------------
module nfcplan_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_en,
   input  wire logic [WIDTH-1:0] wr_data,
   output logic                  full,
   input  wire logic             rd_en,
   output logic [WIDTH-1:0]      rd_data,
   output logic                  valid
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr, do_rd;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign valid   = (count_ff != '0);
   assign rd_data = mem_ff[rd_ptr_ff];
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/nfcplan_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nfcplan_front
// request intake: config registers, argument and range checks, job push
// ----------------------------------------------------------------------------
module nfcplan_front
   import nfcplan_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_push,
   output logic            req_full,
   input  wire logic [1:0] req_action,
   input  wire logic [9:0] req_offset,
   input  wire logic [8:0] req_length,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic       csr_index,
   input  wire logic [9:0] csr_data,
   input  wire logic       job_full,
   output logic            job_push,
   output job_type         job
);

   logic       tag_kind_ff, tag_kind_in;
   logic [9:0] capacity_ff, capacity_in;
   action_type act;
   logic       bad_len, out_of_range, misaligned, writing;

   assign csr_ready = 1'b1;
   assign req_full  = job_full;
   assign job_push  = req_push && !job_full;

   always_comb begin
      tag_kind_in = tag_kind_ff;
      capacity_in = capacity_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_TAG_KIND: tag_kind_in = csr_data[0];
            CSR_CAPACITY: capacity_in = csr_data;
            default:      tag_kind_in = tag_kind_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_kind_ff <= 1'b0;
         capacity_ff <= CAPACITY_RESET;
      end else begin
         tag_kind_ff <= tag_kind_in;
         capacity_ff <= capacity_in;
      end
   end

   assign act          = action_type'(req_action);
   assign writing      = (act == ACT_WRITE);
   assign bad_len      = (req_length == '0) || ({2'b00, req_length} > 11'(MAX_TRANSFER));
   assign out_of_range = (req_offset > capacity_ff) ||
                         ({1'b0, req_length} > (capacity_ff - req_offset));
   assign misaligned   = writing && (tag_kind_ff ? (req_offset[1:0] != 2'd0)
                                                 : (req_offset[3:0] != 4'd0));

   always_comb begin
      job.run         = 1'b0;
      job.rel_session = 1'b0;
      job.status      = ST_OK;
      job.writing     = writing;
      job.paged       = tag_kind_ff;
      job.offset      = req_offset;
      job.length      = req_length;
      priority if (act == ACT_RELEASE) begin
         job.rel_session = 1'b1;
      end else if (act == ACT_UNDEF || bad_len) begin
         job.status = ST_BAD_ARG;
      end else if (out_of_range) begin
         job.status = ST_RANGE;
      end else if (misaligned) begin
         job.status = ST_BAD_ARG;
      end else begin
         job.run = 1'b1;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/nfcplan_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nfcplan_back
// command sequencer: walks a run one result per cycle while the result queue has room, tracks the session
// ----------------------------------------------------------------------------
module nfcplan_back
   import nfcplan_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    job_valid,
   input  wire job_type job,
   output logic         job_pop,
   input  wire logic    res_full,
   output logic         res_push,
   output rsp_type      res
);

   back_state_type   state_ff, state_in;
   logic [9:0]       pos_ff, pos_in;
   logic [8:0]       rem_ff, rem_in;
   logic             writing_ff, writing_in;
   logic             paged_ff, paged_in;
   logic             auth_valid_ff, auth_valid_in;
   logic [3:0]       auth_sector_ff, auth_sector_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic [3:0] skip;
   logic [4:0] room, take;
   logic [9:0] aligned;
   logic [7:0] page_addr, blk_addr;
   logic [5:0] idx;
   logic [3:0] sector;
   logic       beyond, reserved, need_auth, data_done, cap_hit, run_end;

   // per-step datapath
   assign skip      = (paged_ff && writing_ff) ? {2'b00, pos_ff[1:0]} : pos_ff[3:0];
   assign room      = ((paged_ff && writing_ff) ? 5'd4 : 5'd16) - {1'b0, skip};
   assign take      = ({4'd0, room} > rem_ff) ? rem_ff[4:0] : room;
   assign aligned   = pos_ff - {6'd0, skip};
   assign page_addr = aligned[9:2] + 8'(FIRST_DATA_PAGE);
   assign idx       = pos_ff[9:4];
   assign blk_addr  = block_of(idx);
   assign sector    = blk_addr[5:2];
   assign beyond    = !paged_ff && ({1'b0, idx} >= 7'(DATA_BLOCKS));
   assign reserved  = !paged_ff && ((blk_addr == 8'd0) || (blk_addr[1:0] == 2'd3));
   assign need_auth = !paged_ff && (!auth_valid_ff || (sector != auth_sector_ff));
   assign data_done = (rem_ff == {4'd0, take});
   assign cap_hit   = (count_ff == CNT_W'(MAX_RESULTS - 1));

   always_comb begin
      run_end = 1'b0;
      if (beyond || reserved) begin
         run_end = 1'b1;
      end else if (need_auth) begin
         run_end = cap_hit;
      end else begin
         run_end = data_done || cap_hit;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: if (job_valid && job.run) state_in = BK_RUN;
         BK_RUN:  if (!res_full && run_end) state_in = BK_IDLE;
         default: state_in = BK_IDLE;
      endcase
   end

   // outputs and datapath registers
   always_comb begin
      job_pop        = 1'b0;
      res_push       = 1'b0;
      res            = '{command: CMD_NONE, unit_address: 8'd0, skip_bytes: 4'd0,
                         take_bytes: 5'd0, status: ST_OK, last: 1'b0};
      pos_in         = pos_ff;
      rem_in         = rem_ff;
      writing_in     = writing_ff;
      paged_in       = paged_ff;
      auth_valid_in  = auth_valid_ff;
      auth_sector_in = auth_sector_ff;
      count_in       = count_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (job_valid && job.run) begin
               job_pop    = 1'b1;
               pos_in     = job.offset;
               rem_in     = job.length;
               writing_in = job.writing;
               paged_in   = job.paged;
               count_in   = '0;
            end else if (job_valid && !res_full) begin
               // rejected request or session release: one result
               job_pop    = 1'b1;
               res_push   = 1'b1;
               res.status = job.status;
               res.last   = 1'b1;
               if (job.rel_session) auth_valid_in = 1'b0;
            end
         end
         BK_RUN: begin
            if (!res_full) begin
               res_push = 1'b1;
               count_in = count_ff + 1'b1;
               res.last = run_end;
               priority if (beyond) begin
                  res.status = ST_BEYOND;
               end else if (reserved) begin
                  res.status = ST_RESERVED;
               end else if (need_auth) begin
                  res.command      = CMD_AUTH;
                  res.unit_address = blk_addr;
                  auth_valid_in    = 1'b1;
                  auth_sector_in   = sector;
               end else begin
                  res.command      = writing_ff ? CMD_WRITE : CMD_READ;
                  res.unit_address = paged_ff ? page_addr : blk_addr;
                  res.skip_bytes   = skip;
                  res.take_bytes   = take;
                  pos_in           = pos_ff + {5'd0, take};
                  rem_in           = rem_ff - {4'd0, take};
               end
            end
         end
         default: job_pop = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= BK_IDLE;
         pos_ff         <= '0;
         rem_ff         <= '0;
         writing_ff     <= 1'b0;
         paged_ff       <= 1'b0;
         auth_valid_ff  <= 1'b0;
         auth_sector_ff <= '0;
         count_ff       <= '0;
      end else begin
         state_ff       <= state_in;
         pos_ff         <= pos_in;
         rem_ff         <= rem_in;
         writing_ff     <= writing_in;
         paged_ff       <= paged_in;
         auth_valid_ff  <= auth_valid_in;
         auth_sector_ff <= auth_sector_in;
         count_ff       <= count_in;
      end
   end

   // a run in progress always has bytes left
   a_run_has_bytes: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_RUN |-> rem_ff != '0)
      else $error("run active with no bytes left");

   // the result marked last closes the run
   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      res_push && res.last |=> state_ff == BK_IDLE)
      else $error("run continued after last result");

   // an authenticate that does not end the run is followed by a data command to the same block
   a_auth_then_data: assert property (@(posedge clock) disable iff (reset)
      res_push && res.command == CMD_AUTH && !res.last
      |=> !res_push || (res.unit_address == $past(res.unit_address)
                        && res.command != CMD_AUTH))
      else $error("authenticate not followed by its block access");

   // nothing is pushed into a full result queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      res_push |-> !res_full)
      else $error("result pushed while queue full");

endmodule
`default_nettype wire

// ===== rtl/nfc_tag_linear_access_planner_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nfc_tag_linear_access_planner_core
// turns linear read/write/release requests into tag command runs
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake               beat carries
//  -------  ---------  ----------------------  ---------------------------------
//  req_     in         req_push / req_full     action, offset, length
//  rsp_     out        rsp_pop / rsp_empty     command, address, skip, take,
//                                              status, last
//  csr_     in         csr_valid / csr_ready   register index, write data
//
//  a request beat is checked on the spot as it enters the front;
//  a two-entry job queue sits between front and back
//  the back sequencer loads a run without emitting a result, then emits one
//  result per cycle while the result queue has room, and takes no new job
//  until the run ends; a rejected request or release yields a single result
//  rsp_ stalls back up through a two-entry result queue into the sequencer,
//  and from there through the job queue to req_full
//  synchronous active-high reset: queues empty, session forgotten, tag kind
//  block tag, capacity 752 bytes; csr_ never stalls
//
module nfc_tag_linear_access_planner_core
   import nfcplan_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   // request queue side
   input  wire logic       req_push,
   output logic            req_full,
   input  wire logic [1:0] req_action,
   input  wire logic [9:0] req_offset,
   input  wire logic [8:0] req_length,
   // result queue side
   output logic            rsp_empty,
   input  wire logic       rsp_pop,
   output logic [1:0]      rsp_command,
   output logic [7:0]      rsp_unit_address,
   output logic [3:0]      rsp_skip_bytes,
   output logic [4:0]      rsp_take_bytes,
   output logic [2:0]      rsp_status,
   output logic            rsp_last,
   // register writes
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic       csr_index,
   input  wire logic [9:0] csr_data
);

   localparam int JOB_W = $bits(job_type);
   localparam int RSP_W = $bits(rsp_type);

   job_type          job_wr, job_rd;
   logic [JOB_W-1:0] job_rd_bits;
   logic             job_push, job_full, job_valid, job_pop;

   rsp_type          res_wr, res_rd;
   logic [RSP_W-1:0] res_rd_bits;
   logic             res_push, res_full, res_valid;

   // front: config and classification
   nfcplan_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_action (req_action),
      .req_offset (req_offset),
      .req_length (req_length),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .job_full   (job_full),
      .job_push   (job_push),
      .job        (job_wr)
   );

   // decoupling queue between front and back
   nfcplan_fifo #(
      .WIDTH (JOB_W),
      .DEPTH (2)
   ) u_job_q (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (job_push),
      .wr_data (job_wr),
      .full    (job_full),
      .rd_en   (job_pop),
      .rd_data (job_rd_bits),
      .valid   (job_valid)
   );

   assign job_rd = job_type'(job_rd_bits);

   // back: command sequencer and session state
   nfcplan_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job       (job_rd),
      .job_pop   (job_pop),
      .res_full  (res_full),
      .res_push  (res_push),
      .res       (res_wr)
   );

   // result queue, lets the sequencer run ahead of rsp_pop
   nfcplan_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (2)
   ) u_rsp_q (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (res_push),
      .wr_data (res_wr),
      .full    (res_full),
      .rd_en   (rsp_pop),
      .rd_data (res_rd_bits),
      .valid   (res_valid)
   );

   assign res_rd           = rsp_type'(res_rd_bits);
   assign rsp_empty        = !res_valid;
   assign rsp_command      = res_rd.command;
   assign rsp_unit_address = res_rd.unit_address;
   assign rsp_skip_bytes   = res_rd.skip_bytes;
   assign rsp_take_bytes   = res_rd.take_bytes;
   assign rsp_status       = res_rd.status;
   assign rsp_last         = res_rd.last;

endmodule
`default_nettype wire
